### sv/bpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared sizes, command codes, sequencer states and the word search result.
// ----------------------------------------------------------------------------
package bpa_pkg;

  // Capacity and bitmap organization.
  localparam int MAX_PAGES = 65536;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(NUM_WORDS);

  // Field widths of the streams and the configuration register.
  localparam int PAGE_W  = 16;
  localparam int COUNT_W = 17;
  localparam int CMD_W   = 2;

  localparam logic [COUNT_W-1:0] MAX_PAGES_C = COUNT_W'(MAX_PAGES);

  // Command codes carried on the input channel.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2
  } bpa_cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC_CHK,
    ST_RMW
  } bpa_state_t;

  // Result of searching one bitmap word for a free page.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } bpa_find_t;

endpackage

### sv/bpa_bitmap_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpa_bitmap_ram (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [bpa_pkg::WADDR_W-1:0]     wr_addr,
  input  logic [bpa_pkg::WORD_BITS-1:0]   wr_data,
  input  logic [bpa_pkg::WADDR_W-1:0]     rd_addr,
  output logic [bpa_pkg::WORD_BITS-1:0]   rd_data
);

  logic [bpa_pkg::WORD_BITS-1:0] mem [bpa_pkg::NUM_WORDS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### sv/bpa_zero_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free page search in one bitmap word
// Finds the lowest clear bit at or above a start bit whose page lies below
// the page limit.
// ----------------------------------------------------------------------------
module bpa_zero_find (
  input  logic [bpa_pkg::WORD_BITS-1:0] word_data,
  input  logic [bpa_pkg::WADDR_W-1:0]   word_idx,
  input  logic [bpa_pkg::BIT_W-1:0]     start_bit,
  input  logic [bpa_pkg::COUNT_W-1:0]   limit,
  output bpa_pkg::bpa_find_t            result
);

  localparam int LIM_WORD_W = bpa_pkg::COUNT_W - bpa_pkg::BIT_W;

  logic [bpa_pkg::WORD_BITS-1:0] start_mask;
  logic [bpa_pkg::WORD_BITS-1:0] limit_mask;
  logic [bpa_pkg::WORD_BITS-1:0] cand;
  logic [LIM_WORD_W-1:0]         word_ext;
  logic [LIM_WORD_W-1:0]         lim_word;

  // Pages below the start bit and at or past the limit are not candidates.
  always_comb begin
    start_mask = {bpa_pkg::WORD_BITS{1'b1}} << start_bit;
    word_ext   = LIM_WORD_W'(word_idx);
    lim_word   = limit[bpa_pkg::COUNT_W-1:bpa_pkg::BIT_W];
    if (word_ext < lim_word) begin
      limit_mask = {bpa_pkg::WORD_BITS{1'b1}};
    end else if (word_ext == lim_word) begin
      limit_mask = ~({bpa_pkg::WORD_BITS{1'b1}} << limit[bpa_pkg::BIT_W-1:0]);
    end else begin
      limit_mask = '0;
    end
    cand = ~word_data & start_mask & limit_mask;
  end

  // Priority encoder: lowest candidate wins.
  always_comb begin
    result.found   = |cand;
    result.bit_idx = '0;
    for (int i = bpa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        result.bit_idx = bpa_pkg::BIT_W'(i);
      end
    end
  end

endmodule

### sv/bitmap_page_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit physical page allocator over a one-bit-per-page used map.
// ----------------------------------------------------------------------------
// After reset the block fills the bitmap with ones (every page used), one
// memory word per cycle, over all 2048 words; in_tready stays low during
// that pass while configuration writes are taken. Commands run one at a
// time. An allocate examines the bitmap words one after another, starting
// at the word that holds the next-fit pointer, until it finds a free page
// or reaches the limit; the single shared word search and the one read port
// of the bitmap memory make it go one word at a time. Free and reserve do a
// read-modify-write of one word. Out-of-range pages, allocations with the
// pointer at or past the limit and unknown commands register their result
// when accepted, with no bitmap access. The allocation search never wraps below the pointer.
// ----------------------------------------------------------------------------
module bitmap_page_allocator (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: total_pages.
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data,
  // Command stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] page number
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] granted page
  output logic        out_tuser   // [0] ok
);

  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int AW = bpa_pkg::WADDR_W;
  localparam int CW = bpa_pkg::COUNT_W;
  localparam int PW = bpa_pkg::PAGE_W;

  bpa_pkg::bpa_state_t state_r, state_nxt;
  logic [CW-1:0]       ptr_r, ptr_nxt;
  logic [CW-1:0]       total_r;
  logic [AW-1:0]       word_r, word_nxt;
  logic [BW-1:0]       lo_r, lo_nxt;
  logic                set_r, set_nxt;
  logic [AW-1:0]       init_cnt_r, init_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PW-1:0]       out_idx_r, out_idx_nxt;
  logic                out_ok_r, out_ok_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WB-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WB-1:0]       ram_rdata;

  logic [CW-1:0]       limit;
  logic                out_free;
  logic                in_xfer;
  bpa_pkg::bpa_cmd_t   cmd_in;
  bpa_pkg::bpa_find_t  find;
  logic [BW-1:0]       bit_sel;
  logic [WB-1:0]       bit_mask;
  logic [CW-1:0]       word_end;

  // Bitmap storage.
  bpa_bitmap_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Shared word search used by every allocation step.
  bpa_zero_find u_find (
    .word_data (ram_rdata),
    .word_idx  (word_r),
    .start_bit (lo_r),
    .limit     (limit),
    .result    (find)
  );

  // Effective page limit.
  assign limit = (total_r > bpa_pkg::MAX_PAGES_C) ? bpa_pkg::MAX_PAGES_C : total_r;

  // A command is taken only when its result has a free output slot.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == bpa_pkg::ST_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign cmd_in    = bpa_pkg::bpa_cmd_t'(in_tuser);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_idx_r;
  assign out_tuser  = out_ok_r;

  // First page of the word after the current one.
  assign word_end = {1'b0, word_r, {BW{1'b0}}} + CW'(WB);

  // Bit to update: the command's page in a read-modify-write, else the found page.
  assign bit_sel  = (state_r == bpa_pkg::ST_RMW) ? lo_r : find.bit_idx;
  assign bit_mask = {{(WB-1){1'b0}}, 1'b1} << bit_sel;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_wr_en) begin
      total_r <= cfg_wr_data;
    end
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::ST_INIT;
      ptr_r       <= '0;
      init_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      init_cnt_r  <= init_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    word_r    <= word_nxt;
    lo_r      <= lo_nxt;
    set_r     <= set_nxt;
    out_idx_r <= out_idx_nxt;
    out_ok_r  <= out_ok_nxt;
  end

  // Sequencer: next state, memory control and results.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    word_nxt      = word_r;
    lo_nxt        = lo_r;
    set_nxt       = set_r;
    init_cnt_nxt  = init_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_ok_nxt    = out_ok_r;
    ram_we        = 1'b0;
    ram_waddr     = word_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = word_r + AW'(1);

    unique case (state_r)
      bpa_pkg::ST_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = init_cnt_r;
        ram_wdata    = {WB{1'b1}};
        init_cnt_nxt = init_cnt_r + AW'(1);
        if (init_cnt_r == AW'(bpa_pkg::NUM_WORDS - 1)) begin
          state_nxt = bpa_pkg::ST_IDLE;
        end
      end

      bpa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          out_idx_nxt = '0;
          out_ok_nxt  = 1'b0;
          unique case (cmd_in)
            bpa_pkg::CMD_ALLOC: begin
              if (ptr_r >= limit) begin
                out_valid_nxt = 1'b1;
              end else begin
                word_nxt  = ptr_r[BW+AW-1:BW];
                lo_nxt    = ptr_r[BW-1:0];
                ram_raddr = ptr_r[BW+AW-1:BW];
                state_nxt = bpa_pkg::ST_ALLOC_CHK;
              end
            end
            bpa_pkg::CMD_FREE, bpa_pkg::CMD_RESERVE: begin
              if (CW'(in_tdata) < limit) begin
                word_nxt  = in_tdata[BW+AW-1:BW];
                lo_nxt    = in_tdata[BW-1:0];
                set_nxt   = (cmd_in == bpa_pkg::CMD_RESERVE);
                ram_raddr = in_tdata[BW+AW-1:BW];
                state_nxt = bpa_pkg::ST_RMW;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      bpa_pkg::ST_ALLOC_CHK: begin
        // Only the first word starts mid-word.
        lo_nxt = '0;
        if (find.found) begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata | bit_mask;
          ptr_nxt       = {1'b0, word_r, find.bit_idx} + CW'(1);
          out_valid_nxt = 1'b1;
          out_idx_nxt   = PW'({word_r, find.bit_idx});
          out_ok_nxt    = 1'b1;
          state_nxt     = bpa_pkg::ST_IDLE;
        end else if (word_end >= limit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = bpa_pkg::ST_IDLE;
        end else begin
          word_nxt = word_r + AW'(1);
        end
      end

      bpa_pkg::ST_RMW: begin
        ram_we        = 1'b1;
        ram_wdata     = set_r ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        state_nxt     = bpa_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = bpa_pkg::ST_IDLE;
      end
    endcase
  end

  // No result leaves the block before the fill pass is over.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpa_pkg::ST_INIT) |-> !out_valid_r)
    else $error("result produced during bitmap fill");

  // A successful allocation moves the pointer just past the granted page.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bpa_pkg::ST_ALLOC_CHK && find.found)
      |=> (ptr_r == CW'(out_idx_r) + CW'(1)) && out_ok_r)
    else $error("pointer not advanced past allocated page");

  // The pointer changes only when an allocation succeeds.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r == bpa_pkg::ST_ALLOC_CHK && find.found) |=> $stable(ptr_r))
    else $error("pointer moved without an allocation");

  // The bitmap is written only by the fill pass or a finishing command.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == bpa_pkg::ST_INIT || state_r == bpa_pkg::ST_RMW ||
                (state_r == bpa_pkg::ST_ALLOC_CHK && find.found)))
    else $error("unexpected bitmap write");

  // A command is only taken when its result cannot overwrite a pending one.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !(out_valid_r && $past(out_valid_r && !out_tready)))
    else $error("command taken while output slot was busy");

endmodule

### verif/bitmap_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate, free, reserve and unknown commands through the command
// stream under several page counts. A built-in model of the used map and the
// next-fit pointer predicts every result, and each result transfer is checked
// field by field against the oldest prediction. Both stream sides idle at
// random, and a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;

  localparam int CMW = bpa_pkg::CMD_W;
  localparam int PW  = bpa_pkg::PAGE_W;
  localparam int CW  = bpa_pkg::COUNT_W;

  // Command code that the block does not implement.
  localparam logic [CMW-1:0] CMD_UNKNOWN = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct packed {
    logic [PW-1:0] page;
    logic          ok;
  } page_result_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_wr_en = 1'b0;
  logic [CW-1:0]  cfg_wr_data = '0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [PW-1:0]  in_tdata = '0;   // [15:0] page number
  logic [CMW-1:0] in_tuser = '0;   // [1:0] cmd
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [PW-1:0]  out_tdata;       // [15:0] granted page
  logic           out_tuser;       // [0] ok

  // Model state: one bit per page, the next-fit pointer and the page count.
  bit             used_map [bpa_pkg::MAX_PAGES] = '{default: 1'b1};
  logic [CW-1:0]  fit_ptr = '0;
  logic [CW-1:0]  page_count = '0;

  page_result_t page_results_due[$];
  int unsigned  cmds_sent = 0;
  int unsigned  results_seen = 0;
  int unsigned  pages_granted = 0;
  int unsigned  refusals = 0;
  int unsigned  count_settings = 0;
  int unsigned  mismatches = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  send_idle_pct = 32;
  int unsigned  recv_idle_pct = 70;

  bitmap_page_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one command to the model and returns the result it must produce.
  function automatic page_result_t predict_page_cmd(logic [CMW-1:0] cmd,
                                                    logic [PW-1:0] page);
    page_result_t res;
    int unsigned  lim;
    int unsigned  p;
    res = '0;
    lim = (page_count > bpa_pkg::MAX_PAGES_C) ? 32'(bpa_pkg::MAX_PAGES) : 32'(page_count);
    if (cmd == bpa_pkg::CMD_ALLOC) begin
      // Next-fit search upward from the pointer; it never wraps.
      for (p = 32'(fit_ptr); p < lim; p++) begin
        if (!used_map[p]) begin
          used_map[p] = 1'b1;
          fit_ptr = CW'(p + 1);
          res.page = PW'(p);
          res.ok = 1'b1;
          break;
        end
      end
    end else if (cmd == bpa_pkg::CMD_FREE || cmd == bpa_pkg::CMD_RESERVE) begin
      if (page < lim) begin
        used_map[page] = (cmd == bpa_pkg::CMD_RESERVE);
        res.ok = 1'b1;
      end
    end
    if (res.ok && cmd == bpa_pkg::CMD_ALLOC) pages_granted++;
    if (!res.ok) refusals++;
    return res;
  endfunction

  // Result ready with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predicts on each command transfer, checks each result transfer and
  // watches for a hang. Both are handled here so that their order is fixed.
  always @(posedge clk) begin : result_check
    page_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        page_results_due.push_back(predict_page_cmd(in_tuser, in_tdata));
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        results_seen++;
        if (page_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with none expected: page %0d ok %0b",
                     $time, out_tdata, out_tuser);
          end
        end else begin
          want = page_results_due.pop_front();
          if (out_tdata !== want.page) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: granted page expected %0d, actual %0d",
                       $time, want.page, out_tdata);
            end
          end
          if (out_tuser !== want.ok) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: ok expected %0b, actual %0b", $time, want.ok, out_tuser);
            end
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid === 1'b1 && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("bitmap_page_allocator test failed");
        $finish;
      end
    end
  end

  // Sends one command, after a random gap, and waits for its transfer.
  task automatic send_page_cmd(input logic [CMW-1:0] cmd, input logic [PW-1:0] page);
    int unsigned gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= page;
    do @(posedge clk); while (!in_tready);
    cmds_sent++;
  endtask

  // Holds the sender until every outstanding result has arrived.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (results_seen < cmds_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_page_count(input logic [CW-1:0] count);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    page_count = count;
    count_settings++;
  endtask

  // With no managed pages every command is refused.
  task automatic test_empty_map();
    write_page_count('0);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_RESERVE, 16'h0000);
    send_page_cmd(CMD_UNKNOWN, 16'h0000);
  endtask

  // Small map: next-fit order, pages below the pointer skipped, range checks.
  task automatic test_basic_commands();
    wait_results_drained();
    write_page_count(17'd64);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd5);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd3);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd40);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'hFFFF);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd3);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_RESERVE, 16'd63);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd63);
    send_page_cmd(bpa_pkg::CMD_RESERVE, 16'd0);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'd64);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'hFFFF);
    send_page_cmd(bpa_pkg::CMD_RESERVE, 16'hFFFF);
    send_page_cmd(CMD_UNKNOWN, 16'hFFFF);
  endtask

  // Random phases. Most open a window of pages just above the pointer and
  // work inside it; others put the limit at or below the pointer, open the
  // whole map, or send noise.
  task automatic test_random_windows(input int unsigned target);
    int unsigned start, kind, base, limit, lo, hi, count, alloc_pct, r;
    logic [CMW-1:0] cmd;
    logic [PW-1:0]  page;
    start = cmds_sent;
    while (cmds_sent - start < target) begin
      if (cmds_sent - start < target / 3) begin
        send_idle_pct = 32;
        recv_idle_pct = 70;
      end else if (cmds_sent - start < 2 * target / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_results_drained();
      base = 32'(fit_ptr);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        hi = $urandom_range(32, 400);
        limit = (base + hi > 131071) ? 131071 : base + hi;
        lo = base;
        hi = base + hi - 1;
        count = $urandom_range(30, 60);
        alloc_pct = 37;
      end else if (kind == 7) begin
        limit = base - $urandom_range(0, (base < 100) ? base : 100);
        lo = 0;
        hi = base + 16;
        count = $urandom_range(8, 16);
        alloc_pct = 37;
      end else if (kind == 8) begin
        limit = $urandom_range(0, 1) ? bpa_pkg::MAX_PAGES
                                     : bpa_pkg::MAX_PAGES + $urandom_range(0, 65535);
        lo = 0;
        hi = 65535;
        count = $urandom_range(20, 40);
        alloc_pct = 8;
      end else begin
        limit = $urandom_range(0, 131071);
        lo = 0;
        hi = 65535;
        count = $urandom_range(10, 20);
        alloc_pct = 25;
      end
      write_page_count(CW'(limit));
      repeat (count) begin
        if ($urandom_range(99) < alloc_pct) begin
          cmd = bpa_pkg::CMD_ALLOC;
        end else begin
          r = $urandom_range(99);
          if (r < 55) cmd = bpa_pkg::CMD_FREE;
          else if (r < 92) cmd = bpa_pkg::CMD_RESERVE;
          else cmd = CMD_UNKNOWN;
        end
        r = $urandom_range(99);
        if (r < 80) page = PW'($urandom_range(lo, hi));
        else if (r < 90) page = PW'($urandom_range(0, base));
        else page = PW'($urandom);
        send_page_cmd(cmd, page);
      end
    end
  endtask

  // Top of the map: a count above capacity, allocations of the highest pages,
  // and the pointer left at the limit.
  task automatic test_top_of_map();
    int unsigned p;
    int unsigned open_pages[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_results_drained();
    write_page_count(17'h1FFFF);
    // Take every free page above the pointer so that the search goes far.
    for (p = 32'(fit_ptr); p < bpa_pkg::MAX_PAGES; p++) begin
      if (!used_map[p]) open_pages.push_back(p);
    end
    foreach (open_pages[i]) send_page_cmd(bpa_pkg::CMD_RESERVE, PW'(open_pages[i]));
    send_page_cmd(bpa_pkg::CMD_FREE, 16'h8000);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'hFFFF);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'h0000);
    wait_results_drained();
    write_page_count(CW'(bpa_pkg::MAX_PAGES));
    send_page_cmd(bpa_pkg::CMD_FREE, 16'h0000);
    send_page_cmd(bpa_pkg::CMD_ALLOC, 16'hFFFF);
    send_page_cmd(bpa_pkg::CMD_RESERVE, 16'hFFFF);
    send_page_cmd(bpa_pkg::CMD_FREE, 16'hFFFF);
    send_page_cmd(CMD_UNKNOWN, 16'h8000);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_map();
    test_basic_commands();
    test_random_windows(1100);
    test_top_of_map();
    wait_results_drained();
    repeat (20) @(posedge clk);
    if (page_results_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, page_results_due.size());
    end
    $display("Ran %0d commands under %0d page-count settings.", cmds_sent, count_settings);
    $display("Granted %0d pages and refused %0d commands; %0d mismatches.",
             pages_granted, refusals, mismatches);
    if (mismatches == 0) begin
      $display("bitmap_page_allocator test passed");
    end else begin
      $display("bitmap_page_allocator test failed");
    end
    $finish;
  end

endmodule
